// ===== rtl/lpp_pkg.sv =====
// ============================================================================
// Lottery process picker package
// Shared widths, register counts and the sequencer state type.
// ============================================================================
`default_nettype none

package lpp_pkg;

    // Ticket register file and field widths.
    localparam int TICKET_REGS = 8;
    localparam int TICKET_W    = 8;
    localparam int TOTAL_W     = 11;
    localparam int RAND_W      = 16;
    localparam int WINNER_W    = 3;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;

    // One restoring division step per random-value bit.
    localparam int DIV_CNT_W   = 4;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_PICK = 4'b1000
    } lpp_state_t;

endpackage

`default_nettype wire

// ===== rtl/lottery_process_picker.sv =====
// ============================================================================
// Lottery process picker
// Lottery arbiter: sums ready tickets, reduces the random value modulo the
// total with a bit-serial divider and walks the processes to find the winner.
// ============================================================================
// One draw at a time; busy drops in the strobe cycle. The sum and pick walks
// take one process per cycle and the modulo takes one random bit per cycle.
// When no ready process holds tickets, the result comes straight after the sum
// walk. Results cannot be stalled. Reset sets all ticket counts to one and the
// last winner to zero.
`default_nettype none

module lottery_process_picker
    import lpp_pkg::*;
#(
    parameter int NUM_PROCESSES = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Draw command.
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [7:0]            ready_mask,
    input  wire logic [RAND_W-1:0]     random_value,

    // Result beat.
    output logic                       done,
    output logic [WINNER_W-1:0]        winner,
    output logic                       none_ready,
    output logic [TOTAL_W-1:0]         ticket_total,

    // Ticket register writes.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam logic [CNT_W-1:0] LAST_PROC = CNT_W'(NUM_PROCESSES - 1);

    lpp_state_t                 state_reg, state_next;
    logic [TICKET_W-1:0]        tickets_reg [TICKET_REGS];
    logic [WINNER_W-1:0]        last_winner_reg, last_winner_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [DIV_CNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic [NUM_PROCESSES-1:0]   mask_reg, mask_next;
    logic [RAND_W-1:0]          rnd_reg, rnd_next;
    logic [TOTAL_W-1:0]         total_reg, total_next;
    logic [TOTAL_W-1:0]         rem_reg, rem_next;
    logic [TOTAL_W-1:0]         run_reg, run_next;

    logic                       done_reg, done_next;
    logic [WINNER_W-1:0]        winner_reg, winner_next;
    logic                       none_reg, none_next;
    logic [TOTAL_W-1:0]         tot_out_reg, tot_out_next;

    logic [TICKET_W-1:0]        cur_ticket;
    logic [TOTAL_W-1:0]         add_ticket;
    logic [TOTAL_W-1:0]         acc_sum;
    logic [TOTAL_W:0]           div_trial;
    logic                       div_ge;
    logic                       last_proc;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign done         = done_reg;
    assign winner       = winner_reg;
    assign none_ready   = none_reg;
    assign ticket_total = tot_out_reg;

    // Ticket of the process under the walk, counted only when it is ready.
    assign cur_ticket = tickets_reg[WINNER_W'(cnt_reg)];
    assign add_ticket = mask_reg[0] ? TOTAL_W'(cur_ticket) : '0;
    assign last_proc  = (cnt_reg == LAST_PROC);

    // The sum walk and the pick walk share one adder.
    assign acc_sum = (state_reg == ST_PICK) ? (run_reg + add_ticket)
                                            : (total_reg + add_ticket);

    // Restoring division step: shift in the next random bit, subtract if it fits.
    assign div_trial = {rem_reg, rnd_reg[RAND_W-1]};
    assign div_ge    = (div_trial >= {1'b0, total_reg});

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        last_winner_next = last_winner_reg;
        cnt_next         = cnt_reg;
        div_cnt_next     = div_cnt_reg;
        mask_next        = mask_reg;
        rnd_next         = rnd_reg;
        total_next       = total_reg;
        rem_next         = rem_reg;
        run_next         = run_reg;
        done_next        = 1'b0;
        winner_next      = winner_reg;
        none_next        = none_reg;
        tot_out_next     = tot_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mask_next  = ready_mask[NUM_PROCESSES-1:0];
                    rnd_next   = random_value;
                    total_next = '0;
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
            end

            ST_SUM:
            begin
                total_next = acc_sum;
                mask_next  = {mask_reg[0], mask_reg[NUM_PROCESSES-1:1]};
                cnt_next   = cnt_reg + CNT_W'(1);
                if (last_proc)
                begin
                    cnt_next = '0;
                    if (acc_sum == '0)
                    begin
                        // Nothing to draw from: repeat the last winner.
                        done_next    = 1'b1;
                        winner_next  = last_winner_reg;
                        none_next    = 1'b1;
                        tot_out_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        rem_next     = '0;
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                rem_next     = div_ge ? TOTAL_W'(div_trial - {1'b0, total_reg})
                                      : div_trial[TOTAL_W-1:0];
                rnd_next     = {rnd_reg[RAND_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == '1)
                begin
                    cnt_next   = '0;
                    run_next   = '0;
                    state_next = ST_PICK;
                end
            end

            ST_PICK:
            begin
                run_next  = acc_sum;
                mask_next = {mask_reg[0], mask_reg[NUM_PROCESSES-1:1]};
                cnt_next  = cnt_reg + CNT_W'(1);
                // First ready process whose running sum passes the draw wins.
                if ((mask_reg[0] && (rem_reg < acc_sum)) || last_proc)
                begin
                    done_next        = 1'b1;
                    winner_next      = WINNER_W'(cnt_reg);
                    none_next        = 1'b0;
                    tot_out_next     = total_reg;
                    last_winner_next = WINNER_W'(cnt_reg);
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and ticket registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_winner_reg <= '0;
            done_reg        <= 1'b0;
            cnt_reg         <= '0;
            div_cnt_reg     <= '0;
            for (int i = 0; i < TICKET_REGS; i++)
            begin
                tickets_reg[i] <= TICKET_W'(1);
            end
        end
        else
        begin
            state_reg       <= state_next;
            last_winner_reg <= last_winner_next;
            done_reg        <= done_next;
            cnt_reg         <= cnt_next;
            div_cnt_reg     <= div_cnt_next;
            if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(TICKET_REGS)))
            begin
                tickets_reg[WINNER_W'(cfg_index)] <= cfg_data;
            end
        end
    end

    // Datapath shift registers and result payload.
    always_ff @(posedge clk)
    begin
        mask_reg    <= mask_next;
        rnd_reg     <= rnd_next;
        total_reg   <= total_next;
        rem_reg     <= rem_next;
        run_reg     <= run_next;
        winner_reg  <= winner_next;
        none_reg    <= none_next;
        tot_out_reg <= tot_out_next;
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Lottery process picker testbench
// Drives draw commands and ticket register writes into the picker. A built-in
// model predicts winner, none_ready and ticket_total for every accepted draw,
// and a monitor compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import lpp_pkg::*;

    localparam int NPROC         = 8;
    localparam int DRAW_LAT_MAX  = NPROC + 17 + NPROC;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_MAX    = 10;
    localparam int PHASES        = 6;
    localparam int DRAWS_PER_PHS = 250;

    // One predicted result beat.
    typedef struct packed {
        logic [WINNER_W-1:0] winner;
        logic                none_ready;
        logic [TOTAL_W-1:0]  total;
    } draw_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [7:0]            ready_mask = '0;
    logic [RAND_W-1:0]     random_value = '0;
    logic                  done;
    logic [WINNER_W-1:0]   winner;
    logic                  none_ready;
    logic [TOTAL_W-1:0]    ticket_total;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Model state: ticket counts and the last winner.
    bit [TICKET_W-1:0]     ticket_model [TICKET_REGS];
    bit [WINNER_W-1:0]     last_pick;

    draw_result_t          pending_draws [$];
    int                    mismatches = 0;
    bit                    no_idle = 1'b0;

    lottery_process_picker #(
        .NUM_PROCESSES (NPROC)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .ready_mask   (ready_mask),
        .random_value (random_value),
        .done         (done),
        .winner       (winner),
        .none_ready   (none_ready),
        .ticket_total (ticket_total),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Lottery draw: sum the ready tickets, reduce the random value modulo
    // the sum, and take the first ready process whose running sum passes it.
    function automatic draw_result_t predict_draw(input bit [7:0] mask,
                                                  input bit [RAND_W-1:0] rnd);
        draw_result_t r;
        int unsigned  sum;
        int unsigned  running;
        int unsigned  draw;
        bit           found;
        sum     = 0;
        running = 0;
        found   = 1'b0;
        for (int k = 0; k < NPROC; k++)
            if (mask[k])
                sum += ticket_model[k];
        if (sum == 0)
        begin
            r.winner     = last_pick;
            r.none_ready = 1'b1;
            r.total      = '0;
            return r;
        end
        draw = rnd % sum;
        for (int k = 0; k < NPROC; k++)
        begin
            if (mask[k] && !found)
            begin
                running += ticket_model[k];
                if (draw < running)
                begin
                    last_pick = k[WINNER_W-1:0];
                    found     = 1'b1;
                end
            end
        end
        r.winner     = last_pick;
        r.none_ready = 1'b0;
        r.total      = sum[TOTAL_W-1:0];
        return r;
    endfunction

    // Gap before the next draw: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Send one draw command and wait for it to be taken. With no gap, start
    // stays high so that the next call can follow at once.
    task automatic send_draw(input bit [7:0] mask, input bit [RAND_W-1:0] rnd);
        int gap;
        start        <= 1'b1;
        ready_mask   <= mask;
        random_value <= rnd;
        do
            @(posedge clk);
        while (busy);
        pending_draws.push_back(predict_draw(mask, rnd));
        gap = pick_gap();
        if (gap > 0)
        begin
            start        <= 1'b0;
            ready_mask   <= 8'($urandom);
            random_value <= RAND_W'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop issuing draws and wait until every predicted beat has arrived.
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
    endtask

    // One ticket register write; valid stays high for a following write.
    task automatic write_ticket(input bit [CFG_IDX_W-1:0] idx,
                                input bit [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < TICKET_REGS)
            ticket_model[idx[WINNER_W-1:0]] = data;
    endtask

    // Load all eight ticket counts, plus a few writes to unused indexes.
    task automatic load_tickets(input bit [8*TICKET_W-1:0] counts, input int stray);
        wait_drained();
        for (int k = 0; k < TICKET_REGS; k++)
            write_ticket(k[CFG_IDX_W-1:0], counts[k*TICKET_W +: TICKET_W]);
        for (int k = 0; k < stray; k++)
            write_ticket(CFG_IDX_W'($urandom_range(TICKET_REGS, 15)),
                         CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Reset ticket counts: every process holds one ticket.
    task automatic test_reset_defaults();
        send_draw(8'h00, 16'h1234);
        send_draw(8'hFF, 16'h0000);
        send_draw(8'hFF, 16'hFFFF);
        send_draw(8'h80, 16'd1234);
        send_draw(8'h00, 16'hFFFF);
    endtask

    // Ready processes holding no tickets never win; with none left the
    // previous winner is repeated.
    task automatic test_zero_ticket_procs();
        load_tickets({8'd0, 8'd2, 8'd0, 8'd0, 8'd5, 8'd0, 8'd3, 8'd0}, 0);
        send_draw(8'h35, 16'h0F0F);
        send_draw(8'hFF, 16'h0000);
        send_draw(8'h4B, 16'd9);
        send_draw(8'h01, 16'hFFFF);
    endtask

    // Largest and mixed ticket counts, with writes to unused indexes ignored.
    task automatic test_ticket_extremes();
        load_tickets({8{8'hFF}}, 8);
        send_draw(8'hFF, 16'hFFFF);
        send_draw(8'hFF, 16'd2039);
        send_draw(8'hFF, 16'd2040);
        send_draw(8'h01, 16'd255);
        send_draw(8'hAA, 16'hAAAA);
        send_draw(8'h55, 16'h5555);
        load_tickets({8'd254, 8'd0, 8'd1, 8'd255, 8'd0, 8'd1, 8'd0, 8'd255}, 2);
        repeat (3) send_draw(8'($urandom), RAND_W'($urandom));
    endtask

    // Random draws over several ticket settings and idling patterns.
    task automatic test_random_draws();
        bit [8*TICKET_W-1:0] counts;
        bit [7:0]            mask;
        bit [RAND_W-1:0]     rnd;
        int                  r;
        for (int phs = 0; phs < PHASES; phs++)
        begin
            for (int k = 0; k < TICKET_REGS; k++)
            begin
                case (phs)
                    1:       counts[k*TICKET_W +: TICKET_W] = 8'($urandom_range(0, 3));
                    2:       counts[k*TICKET_W +: TICKET_W] = 8'hFF;
                    3:       counts[k*TICKET_W +: TICKET_W] =
                                 ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom);
                    4:       counts[k*TICKET_W +: TICKET_W] = 8'd0;
                    default: counts[k*TICKET_W +: TICKET_W] = 8'($urandom);
                endcase
            end
            if (phs == 4)
                counts[$urandom_range(0, NPROC-1)*TICKET_W +: TICKET_W] =
                    8'($urandom_range(1, 255));
            load_tickets(counts, $urandom_range(0, 2));
            no_idle = (phs % 3 == 2);
            for (int n = 0; n < DRAWS_PER_PHS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    mask = 8'h00;
                else if (r < 25)
                    mask = 8'h01 << $urandom_range(0, 7);
                else if (r < 35)
                    mask = 8'hFF;
                else
                    mask = 8'($urandom);
                r = $urandom_range(0, 99);
                if (r < 10)
                    rnd = '0;
                else if (r < 20)
                    rnd = '1;
                else
                    rnd = RAND_W'($urandom);
                send_draw(mask, rnd);
            end
        end
        no_idle = 1'b0;
    endtask

    // Compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        draw_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_draws.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"%0t: result beat with no draw pending: ",
                              "winner=%0d none_ready=%0b total=%0d"},
                             $realtime, winner, none_ready, ticket_total);
            end
            else
            begin
                exp_res = pending_draws.pop_front();
                if (winner !== exp_res.winner || none_ready !== exp_res.none_ready ||
                    ticket_total !== exp_res.total)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"%0t: mismatch: winner %0d/%0d none_ready %0b/%0b ",
                                  "total %0d/%0d (exp/act)"},
                                 $realtime, exp_res.winner, winner, exp_res.none_ready,
                                 none_ready, exp_res.total, ticket_total);
                end
            end
        end
    end

    // Watchdog: give up when nothing moves for too long.
    always @(posedge clk)
    begin
        int stall_cycles;
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        for (int k = 0; k < TICKET_REGS; k++)
            ticket_model[k] = 1;
        last_pick = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_ticket_procs();
        test_ticket_extremes();
        test_random_draws();

        wait_drained();
        repeat (DRAW_LAT_MAX + 8) @(posedge clk);
        if (mismatches == 0 && pending_draws.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
